### rtl/core/trq_pkg.sv
// Shared types, constants and helpers for the tree relation query block.
// Used by tree_relation_query; has no dependencies of its own.
`timescale 1ns / 1ps

package trq_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;
  localparam int REL_W  = 3;
  localparam int ADDR_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [REL_W-1:0] REL_SAME         = 3'd0;
  localparam logic [REL_W-1:0] REL_FIRST_BELOW  = 3'd1;
  localparam logic [REL_W-1:0] REL_SECOND_BELOW = 3'd2;
  localparam logic [REL_W-1:0] REL_COMMON       = 3'd3;
  localparam logic [REL_W-1:0] REL_UNRELATED    = 3'd4;
  localparam logic [REL_W-1:0] REL_CYCLE        = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEPTH_A,
    ST_DEPTH_B,
    ST_LIFT_A,
    ST_LIFT_B,
    ST_WALK_A,
    ST_WALK_B,
    ST_DONE
  } state_t;

  function automatic logic in_range(input logic [NODE_W-1:0] node);
    return 32'(node) < NODES;
  endfunction

  // A node without a table entry acts as its own root.
  function automatic logic [NODE_W-1:0] parent_of(input logic [NODE_W-1:0] node,
                                                  input logic [NODE_W-1:0] rdata);
    return in_range(node) ? rdata : node;
  endfunction

endpackage

### rtl/core/tree_relation_query.sv
// Tree relation query: parent table in one RAM, walked one read per cycle.
// After reset a clearing pass sets every entry to itself; in_ready stays low during it.
// A write transaction is written to the RAM as it is accepted, and the block stays idle.
// A query is walked through the single RAM read port, with depth counts da and db (a loop
// ends a depth count after NODES steps); no new request is taken until its result has
// moved into the output register, which waits out any output stall. Equal nodes skip the
// walk. The result sits in an output register.
`timescale 1ns / 1ps

module tree_relation_query (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [trq_pkg::NODE_W-1:0]     in_first_node,
  input  logic [trq_pkg::NODE_W-1:0]     in_second_node,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [trq_pkg::REL_W-1:0]      out_relation
);

  trq_pkg::state_t state_r, state_nxt;
  logic [trq_pkg::NODE_W-1:0] a_r, a_nxt, b_r, b_nxt, w_r, w_nxt;
  logic [trq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, da_r, da_nxt;
  logic                       pend_r, pend_nxt;
  logic [trq_pkg::REL_W-1:0]  rel_r, rel_nxt;
  logic [trq_pkg::ADDR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [trq_pkg::REL_W-1:0]  out_relation_r, out_relation_nxt;

  logic                       ram_we;
  logic [trq_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [trq_pkg::NODE_W-1:0] ram_wdata, ram_rdata;
  logic [trq_pkg::NODE_W-1:0] pw, pa, pb;
  logic                       out_load;
  logic                       in_fire;

  trq_ram #(
    .WIDTH(trq_pkg::NODE_W),
    .DEPTH(trq_pkg::NODES)
  ) u_parent_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pw = trq_pkg::parent_of(w_r, ram_rdata);
  assign pa = trq_pkg::parent_of(a_r, ram_rdata);
  assign pb = trq_pkg::parent_of(b_r, ram_rdata);
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trq_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    w_r            <= w_nxt;
    da_r           <= da_nxt;
    rel_r          <= rel_nxt;
    out_relation_r <= out_relation_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    w_nxt       = w_r;
    cnt_nxt     = cnt_r;
    da_nxt      = da_r;
    pend_nxt    = 1'b0;
    rel_nxt     = rel_r;
    clr_idx_nxt = clr_idx_r;
    ram_we      = 1'b0;
    ram_waddr   = trq_pkg::ADDR_W'(in_first_node);
    ram_wdata   = in_second_node;
    ram_raddr   = trq_pkg::ADDR_W'(w_r);
    in_ready    = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      trq_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = trq_pkg::NODE_W'(clr_idx_r);
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (32'(clr_idx_r) == trq_pkg::NODES - 1) begin
          state_nxt = trq_pkg::ST_IDLE;
        end
      end

      trq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_req_type == trq_pkg::REQ_WRITE) begin
            ram_we = trq_pkg::in_range(in_first_node);
          end else begin
            a_nxt   = in_first_node;
            b_nxt   = in_second_node;
            w_nxt   = in_first_node;
            cnt_nxt = '0;
            if (in_first_node == in_second_node) begin
              rel_nxt   = trq_pkg::REL_SAME;
              state_nxt = trq_pkg::ST_DONE;
            end else begin
              state_nxt = trq_pkg::ST_DEPTH_A;
            end
          end
        end
      end

      trq_pkg::ST_DEPTH_A, trq_pkg::ST_DEPTH_B: begin
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else if (pw == w_r) begin
          // Root reached: cnt_r holds this node's depth.
          if (state_r == trq_pkg::ST_DEPTH_A) begin
            da_nxt    = cnt_r;
            cnt_nxt   = '0;
            w_nxt     = b_r;
            state_nxt = trq_pkg::ST_DEPTH_B;
          end else if (da_r > cnt_r) begin
            w_nxt     = a_r;
            cnt_nxt   = da_r - cnt_r;
            da_nxt    = cnt_r;
            state_nxt = trq_pkg::ST_LIFT_A;
          end else if (cnt_r > da_r) begin
            w_nxt     = b_r;
            cnt_nxt   = cnt_r - da_r;
            state_nxt = trq_pkg::ST_LIFT_B;
          end else if (da_r == '0) begin
            rel_nxt   = trq_pkg::REL_UNRELATED;
            state_nxt = trq_pkg::ST_DONE;
          end else begin
            cnt_nxt   = da_r;
            state_nxt = trq_pkg::ST_WALK_A;
          end
        end else if (cnt_r >= trq_pkg::CNT_W'(trq_pkg::NODES)) begin
          rel_nxt   = trq_pkg::REL_CYCLE;
          state_nxt = trq_pkg::ST_DONE;
        end else begin
          w_nxt     = pw;
          cnt_nxt   = cnt_r + 1'b1;
          ram_raddr = trq_pkg::ADDR_W'(pw);
          pend_nxt  = 1'b1;
        end
      end

      trq_pkg::ST_LIFT_A, trq_pkg::ST_LIFT_B: begin
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else begin
          w_nxt   = pw;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == trq_pkg::CNT_W'(1)) begin
            if (state_r == trq_pkg::ST_LIFT_A) begin
              a_nxt = pw;
            end else begin
              b_nxt = pw;
            end
            if (state_r == trq_pkg::ST_LIFT_A && pw == b_r) begin
              rel_nxt   = trq_pkg::REL_FIRST_BELOW;
              state_nxt = trq_pkg::ST_DONE;
            end else if (state_r == trq_pkg::ST_LIFT_B && pw == a_r) begin
              rel_nxt   = trq_pkg::REL_SECOND_BELOW;
              state_nxt = trq_pkg::ST_DONE;
            end else if (da_r == '0) begin
              rel_nxt   = trq_pkg::REL_UNRELATED;
              state_nxt = trq_pkg::ST_DONE;
            end else begin
              cnt_nxt   = da_r;
              state_nxt = trq_pkg::ST_WALK_A;
            end
          end else begin
            ram_raddr = trq_pkg::ADDR_W'(pw);
            pend_nxt  = 1'b1;
          end
        end
      end

      trq_pkg::ST_WALK_A: begin
        if (!pend_r) begin
          ram_raddr = trq_pkg::ADDR_W'(a_r);
          pend_nxt  = 1'b1;
        end else begin
          // Hold the parent of a while the parent of b is read.
          w_nxt     = pa;
          ram_raddr = trq_pkg::ADDR_W'(b_r);
          pend_nxt  = 1'b1;
          state_nxt = trq_pkg::ST_WALK_B;
        end
      end

      trq_pkg::ST_WALK_B: begin
        a_nxt   = w_r;
        b_nxt   = pb;
        cnt_nxt = cnt_r - 1'b1;
        if (w_r == pb) begin
          rel_nxt   = trq_pkg::REL_COMMON;
          state_nxt = trq_pkg::ST_DONE;
        end else if (cnt_r == trq_pkg::CNT_W'(1)) begin
          rel_nxt   = trq_pkg::REL_UNRELATED;
          state_nxt = trq_pkg::ST_DONE;
        end else begin
          ram_raddr = trq_pkg::ADDR_W'(w_r);
          pend_nxt  = 1'b1;
          state_nxt = trq_pkg::ST_WALK_A;
        end
      end

      trq_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = trq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = trq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_relation_nxt = out_relation_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (out_load) begin
      out_relation_nxt = rel_r;
      out_valid_nxt    = 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_relation = out_relation_r;

  // The walk step counter never runs past the table size.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= trq_pkg::CNT_W'(trq_pkg::NODES))
    else $error("walk counter exceeded table size");

  // The second half of a lockstep step always has read data waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trq_pkg::ST_WALK_B |-> pend_r)
    else $error("lockstep step without pending read");

  // A query on one node goes straight to the done state with the same-node relation.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req_type == trq_pkg::REQ_QUERY && in_first_node == in_second_node
    |=> state_r == trq_pkg::ST_DONE && rel_r == trq_pkg::REL_SAME)
    else $error("same-node query did not short-circuit");

  // Only legal relation codes reach the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_relation_r <= trq_pkg::REL_CYCLE)
    else $error("illegal relation code");

endmodule

### rtl/core/trq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/tree_relation_query_tb.sv
// Self-checking testbench for tree_relation_query: parent writes and relation queries.
// Depends on trq_pkg and the tree_relation_query RTL; keeps its own copy of the parent table.
`timescale 1ns / 1ps

class relation_tracker;
  logic [trq_pkg::NODE_W-1:0] parent_copy [trq_pkg::NODES];
  logic [trq_pkg::REL_W-1:0]  pending_relations [$];
  int unsigned                mismatches;

  function new();
    for (int i = 0; i < trq_pkg::NODES; i++) parent_copy[i] = trq_pkg::NODE_W'(i);
    mismatches = 0;
  endfunction

  function logic [trq_pkg::NODE_W-1:0] step_up(logic [trq_pkg::NODE_W-1:0] node);
    return (int'(node) < trq_pkg::NODES) ? parent_copy[node] : node;
  endfunction

  // Returns 0 when the climb runs past NODES steps, which means a loop above the node.
  function bit depth_of(logic [trq_pkg::NODE_W-1:0] node, output int unsigned depth);
    int unsigned steps = 0;
    while (step_up(node) != node) begin
      if (steps >= trq_pkg::NODES) return 1'b0;
      node = step_up(node);
      steps++;
    end
    depth = steps;
    return 1'b1;
  endfunction

  function logic [trq_pkg::REL_W-1:0] relation_of(logic [trq_pkg::NODE_W-1:0] a,
                                                   logic [trq_pkg::NODE_W-1:0] b);
    int unsigned da = 0;
    int unsigned db = 0;
    if (a == b) return trq_pkg::REL_SAME;
    if (!depth_of(a, da)) return trq_pkg::REL_CYCLE;
    if (!depth_of(b, db)) return trq_pkg::REL_CYCLE;
    if (da > db) begin
      repeat (da - db) a = step_up(a);
      if (a == b) return trq_pkg::REL_FIRST_BELOW;
      da = db;
    end else if (db > da) begin
      repeat (db - da) b = step_up(b);
      if (a == b) return trq_pkg::REL_SECOND_BELOW;
    end
    while (da > 0) begin
      a = step_up(a);
      b = step_up(b);
      if (a == b) return trq_pkg::REL_COMMON;
      da--;
    end
    return trq_pkg::REL_UNRELATED;
  endfunction

  function void note_input(logic req, logic [trq_pkg::NODE_W-1:0] a,
                           logic [trq_pkg::NODE_W-1:0] b);
    if (req == trq_pkg::REQ_WRITE) begin
      if (int'(a) < trq_pkg::NODES) parent_copy[a] = b;
    end else begin
      pending_relations = {pending_relations, relation_of(a, b)};
    end
  endfunction

  function void check_result(logic [trq_pkg::REL_W-1:0] got);
    logic [trq_pkg::REL_W-1:0] want;
    if (pending_relations.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transaction: expected none, actual relation %0d", got);
      return;
    end
    want = pending_relations.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("relation mismatch: expected %0d, actual %0d", want, got);
    end
  endfunction
endclass

module tree_relation_query_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_TARGET = 1050;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_req_type;
  logic [trq_pkg::NODE_W-1:0] in_first_node;
  logic [trq_pkg::NODE_W-1:0] in_second_node;
  logic                       out_valid;
  logic                       out_ready;
  logic [trq_pkg::REL_W-1:0]  out_relation;

  int                send_idle_pct;
  int                recv_idle_pct;
  int                items_sent;
  int                quiet_cycles;

  relation_tracker   tracker = new();

  tree_relation_query u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_first_node (in_first_node),
    .in_second_node(in_second_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_relation  (out_relation)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_relation);
  end

  // Ends the run when the block stops moving transactions altogether.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic req, input logic [trq_pkg::NODE_W-1:0] a,
                           input logic [trq_pkg::NODE_W-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_first_node  <= a;
    in_second_node <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(req, a, b);
    items_sent++;
    // Receiver-heavy idling first, then sender-heavy, then a clean stretch.
    if (items_sent < 350) begin
      send_idle_pct <= 30;
      recv_idle_pct <= 55;
    end else if (items_sent < 700) begin
      send_idle_pct <= 55;
      recv_idle_pct <= 30;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  endtask

  task automatic write_parent(input int unsigned node, input int unsigned parent);
    send_item(trq_pkg::REQ_WRITE, trq_pkg::NODE_W'(node), trq_pkg::NODE_W'(parent));
  endtask

  task automatic ask(input int unsigned a, input int unsigned b);
    send_item(trq_pkg::REQ_QUERY, trq_pkg::NODE_W'(a), trq_pkg::NODE_W'(b));
  endtask

  initial begin
    int unsigned base;
    int unsigned size;
    int unsigned pick;
    int unsigned a;
    int unsigned b;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = trq_pkg::REQ_WRITE;
    in_first_node  = '0;
    in_second_node = '0;
    send_idle_pct  = 30;
    recv_idle_pct  = 55;
    items_sent     = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: roots, extremes, ancestry in both directions, loops and their repair.
    ask(0, 0);
    ask(0, 1023);
    ask(1023, 1023);
    write_parent(1023, 0);
    write_parent(512, 1023);
    ask(512, 0);
    ask(0, 512);
    ask(1023, 512);
    write_parent(5, 0);
    ask(512, 5);
    ask(5, 1023);
    write_parent(700, 701);
    write_parent(701, 700);
    ask(700, 700);
    ask(700, 701);
    ask(0, 700);
    write_parent(702, 700);
    ask(702, 5);
    write_parent(700, 700);
    ask(701, 702);
    ask(702, 700);
    write_parent(1023, 1023);
    ask(512, 5);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // Acyclic forest: every parent lies below its child within the block of nodes.
        size = $urandom_range(8, 40);
        base = $urandom_range(0, trq_pkg::NODES - size);
        for (int unsigned k = 0; k < size; k++) begin
          if (k == 0 || $urandom_range(0, 5) == 0) write_parent(base + k, base + k);
          else if ($urandom_range(0, 1) == 1) write_parent(base + k, base + k - 1);
          else write_parent(base + k, base + $urandom_range(0, k - 1));
        end
        repeat ($urandom_range(size / 2, size)) begin
          a = base + $urandom_range(0, size - 1);
          b = ($urandom_range(0, 9) == 0) ? a : base + $urandom_range(0, size - 1);
          ask(a, b);
        end
      end else if (pick == 6) begin
        size = $urandom_range(60, 200);
        base = $urandom_range(0, trq_pkg::NODES - size);
        write_parent(base, base);
        for (int unsigned k = 1; k < size; k++) write_parent(base + k, base + k - 1);
        repeat (12) ask(base + $urandom_range(0, size - 1), base + $urandom_range(0, size - 1));
      end else if (pick == 7) begin
        // A chain whose top is bent back onto one of its own nodes.
        size = $urandom_range(4, 20);
        base = $urandom_range(0, trq_pkg::NODES - size);
        write_parent(base, base);
        for (int unsigned k = 1; k < size; k++) write_parent(base + k, base + k - 1);
        write_parent(base, base + $urandom_range(0, size - 1));
        repeat (8) begin
          a = base + $urandom_range(0, size - 1);
          b = ($urandom_range(0, 3) == 0) ? a : base + $urandom_range(0, size - 1);
          ask(a, b);
        end
      end else begin
        repeat (20)
          send_item(1'($urandom_range(0, 1)), trq_pkg::NODE_W'($urandom_range(0, 1023)),
                    trq_pkg::NODE_W'($urandom_range(0, 1023)));
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending_relations.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_relations.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
